>>> sv/tas_pkg.sv
// Shared types and constants of the set-associative tag store.
// No dependencies; every other design file but tas_ram refers to it by scoped names.
`default_nettype none

package tas_pkg;

  // Channel field widths
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned SET_IN_W = 6;
  localparam int unsigned TAG_IN_W = 20;
  localparam int unsigned CNT_W    = 32;

  // Default geometry
  localparam int unsigned DEF_SET_BITS = 6;
  localparam int unsigned DEF_WAYS     = 4;
  localparam int unsigned DEF_TAG_BITS = 20;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 3'd0,
    MODE_FILL   = 3'd1,
    MODE_TOUCH  = 3'd2,
    MODE_EVICT  = 3'd3,
    MODE_ERASE  = 3'd4
  } mode_e;

  // Per-item flags and evicted tag from the update unit
  typedef struct packed {
    logic                hit;
    logic                fill_done;
    logic                erase_done;
    logic                evicted_valid;
    logic [TAG_IN_W-1:0] evicted_tag;
  } tas_res_t;

endpackage

`default_nettype wire

>>> sv/tas_req_if.sv
// Request channel: operation, set and tag, valid/ready handshake.
// Depends on tas_pkg for field widths.
`default_nettype none

interface tas_req_if;
  logic                         valid;
  logic                         ready;
  logic [tas_pkg::MODE_W-1:0]   mode;
  logic [tas_pkg::SET_IN_W-1:0] set_index;
  logic [tas_pkg::TAG_IN_W-1:0] tag;

  modport source (output valid, mode, set_index, tag, input ready);
  modport sink   (input valid, mode, set_index, tag, output ready);
endinterface

`default_nettype wire

>>> sv/tas_rsp_if.sv
// Response channel: per-item flags, evicted tag and running counts.
// Depends on tas_pkg for field widths.
`default_nettype none

interface tas_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         fill_done;
  logic                         erase_done;
  logic                         evicted_valid;
  logic [tas_pkg::TAG_IN_W-1:0] evicted_tag;
  logic [tas_pkg::CNT_W-1:0]    lookup_count;
  logic [tas_pkg::CNT_W-1:0]    hit_count;

  modport source (output valid, hit, fill_done, erase_done, evicted_valid, evicted_tag,
                  lookup_count, hit_count, input ready);
  modport sink   (input valid, hit, fill_done, erase_done, evicted_valid, evicted_tag,
                  lookup_count, hit_count, output ready);
endinterface

`default_nettype wire

>>> sv/tas_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tas_ram #(
  parameter  int unsigned WIDTH = 1,
  parameter  int unsigned DEPTH = 2,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/tas_lru.sv
// Set update unit: tag match, empty-way and LRU-way search, rank promotion.
// Works on one set row read from the RAMs; depends on tas_pkg.
`default_nettype none

module tas_lru #(
  parameter int unsigned WAYS     = tas_pkg::DEF_WAYS,
  parameter int unsigned TAG_BITS = tas_pkg::DEF_TAG_BITS,
  parameter int unsigned RW       = 2
) (
  input  wire tas_pkg::mode_e                mode_i,
  input  wire logic [TAG_BITS-1:0]           tag_i,
  input  wire logic [WAYS-1:0][TAG_BITS-1:0] tags_i,
  input  wire logic [WAYS-1:0]               valid_i,
  input  wire logic [WAYS-1:0][RW-1:0]       rank_i,
  output logic                               tag_we_o,
  output logic      [WAYS-1:0][TAG_BITS-1:0] tags_o,
  output logic      [WAYS-1:0]               valid_o,
  output logic      [WAYS-1:0][RW-1:0]       rank_o,
  output tas_pkg::tas_res_t                  res_o
);

  localparam int unsigned EXT_W =
      (TAG_BITS > tas_pkg::TAG_IN_W) ? TAG_BITS : tas_pkg::TAG_IN_W;

  typedef logic [WAYS-1:0][RW-1:0] rank_row_t;

  logic          m_found, e_found, l_found;
  logic [RW-1:0] m_way, e_way, l_way;
  logic [EXT_W-1:0] ev_ext;

  // Way w becomes most recent; ways ranked above its old rank move down by one.
  function automatic rank_row_t promote(rank_row_t r, logic [RW-1:0] w);
    rank_row_t     n;
    logic [RW-1:0] x;
    n = r;
    x = r[w];
    for (int j = 0; j < WAYS; j++) begin
      if ((RW'(j) != w) && (r[j] > x)) begin
        n[j] = r[j] - 1'b1;
      end
    end
    n[w] = RW'(WAYS - 1);
    return n;
  endfunction

  // Lowest qualifying way wins: scan downward so the last hit is way 0 side.
  always_comb begin
    m_found = 1'b0;
    e_found = 1'b0;
    l_found = 1'b0;
    m_way   = '0;
    e_way   = '0;
    l_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && (tags_i[w] == tag_i)) begin
        m_found = 1'b1;
        m_way   = RW'(w);
      end
      if (!valid_i[w]) begin
        e_found = 1'b1;
        e_way   = RW'(w);
      end
      if (rank_i[w] == '0) begin
        l_found = 1'b1;
        l_way   = RW'(w);
      end
    end
  end

  assign ev_ext = EXT_W'(tags_i[l_way]);

  always_comb begin
    tag_we_o = 1'b0;
    tags_o   = tags_i;
    valid_o  = valid_i;
    rank_o   = rank_i;
    res_o    = '0;
    unique case (mode_i) inside
      tas_pkg::MODE_LOOKUP, tas_pkg::MODE_TOUCH: begin
        if (m_found) begin
          rank_o    = promote(rank_i, m_way);
          res_o.hit = 1'b1;
        end
      end
      tas_pkg::MODE_FILL: begin
        if (e_found) begin
          tag_we_o        = 1'b1;
          tags_o[e_way]   = tag_i;
          valid_o[e_way]  = 1'b1;
          rank_o          = promote(rank_i, e_way);
          res_o.fill_done = 1'b1;
        end
      end
      tas_pkg::MODE_EVICT: begin
        if (l_found) begin
          if (valid_i[l_way]) begin
            res_o.evicted_valid = 1'b1;
            res_o.evicted_tag   = ev_ext[tas_pkg::TAG_IN_W-1:0];
          end
          valid_o[l_way] = 1'b0;
        end
      end
      tas_pkg::MODE_ERASE: begin
        if (m_found) begin
          valid_o[m_way]   = 1'b0;
          res_o.erase_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/set_assoc_tag_store_lru_unit.sv
// Set-associative cache tag store with per-set LRU ranks.
// Channels: req_i (sink) carries mode, set_index and tag; rsp_o (source)
// returns one result per request: hit, fill_done, erase_done,
// evicted_valid, evicted_tag and the running lookup and hit counts
// (values after that request). Both use a valid/ready transfer.
// Storage: a tag RAM and a metadata RAM (valid bits and ranks), one row
// per set, both with a registered read.
// Timing: a request is taken in IDLE and its set row is read; in EXEC,
// once the output register is free, the row is updated, written back
// and the result registered. The read-modify-write of a set row ends
// before the next request is taken, as the next request is taken only
// after the write back, so no forwarding is needed.
// Reset: valid bits and ranks are initialized by a sweep over all
// 2**SET_BITS sets (one set per cycle) during which req_i.ready stays
// low. The counters reset to zero; tags are not cleared.
// Stall: a pending result holds in the output register while rsp_o.ready
// is low; a request already taken waits before its write back until the
// output register is free.
// Depends on tas_pkg, tas_req_if, tas_rsp_if, tas_ram and tas_lru.
`default_nettype none

module set_assoc_tag_store_lru_unit #(
  parameter int unsigned SET_BITS = tas_pkg::DEF_SET_BITS,
  parameter int unsigned WAYS     = tas_pkg::DEF_WAYS,
  parameter int unsigned TAG_BITS = tas_pkg::DEF_TAG_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tas_req_if.sink    req_i,
  tas_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned DEPTH    = 2 ** SET_BITS;
  localparam int unsigned LAST_SET = DEPTH - 1;
  localparam int unsigned RW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned META_W   = WAYS * (1 + RW);
  localparam int unsigned TROW_W   = WAYS * TAG_BITS;
  localparam int unsigned SX_W     =
      (IDX_W > tas_pkg::SET_IN_W) ? IDX_W : tas_pkg::SET_IN_W;
  localparam int unsigned EXT_W    =
      (TAG_BITS > tas_pkg::TAG_IN_W) ? TAG_BITS : tas_pkg::TAG_IN_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                      state_q;
  logic [IDX_W-1:0]            clr_cnt_q;
  tas_pkg::mode_e              mode_q;
  logic [IDX_W-1:0]            set_q;
  logic [TAG_BITS-1:0]         tag_q;
  logic                        out_valid_q;
  tas_pkg::tas_res_t           res_q;
  logic [tas_pkg::CNT_W-1:0]   lookup_cnt_q, lookup_cnt_d;
  logic [tas_pkg::CNT_W-1:0]   hit_cnt_q, hit_cnt_d;

  logic                        req_fire;
  logic                        exec_go;
  logic [SX_W-1:0]             set_ext;
  logic [IDX_W-1:0]            set_idx;
  logic [EXT_W-1:0]            tag_ext;

  logic [TROW_W-1:0]           tag_rd;
  logic [META_W-1:0]           meta_rd;
  logic [WAYS-1:0][TAG_BITS-1:0] tags_rd, tags_new;
  logic [WAYS-1:0]             valid_rd, valid_new;
  logic [WAYS-1:0][RW-1:0]     rank_rd, rank_new, rank_init;
  logic                        lru_tag_we;
  tas_pkg::tas_res_t           lru_res;

  logic                        meta_we, tag_we;
  logic [IDX_W-1:0]            meta_waddr;
  logic [META_W-1:0]           meta_wdata;
  logic [WAYS-1:0]             mru_mask;

  assign req_fire = req_i.valid && req_i.ready;
  assign exec_go  = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);

  assign set_ext = SX_W'(req_i.set_index);
  assign set_idx = (SET_BITS == 0) ? '0 : set_ext[IDX_W-1:0];
  assign tag_ext = EXT_W'(req_i.tag);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rank_init[w] = RW'(w);
    end
  end

  assign tags_rd  = tag_rd;
  assign valid_rd = meta_rd[WAYS-1:0];
  assign rank_rd  = meta_rd[META_W-1:WAYS];

  // Sweep writes the reset row; otherwise the updated row goes back at exec.
  assign meta_we    = (state_q == ST_CLEAR) || exec_go;
  assign meta_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : set_q;
  assign meta_wdata = (state_q == ST_CLEAR) ? {rank_init, {WAYS{1'b0}}}
                                            : {rank_new, valid_new};
  assign tag_we     = exec_go && lru_tag_we;

  tas_ram #(
    .WIDTH (TROW_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (set_q),
    .wdata_i (tags_new),
    .re_i    (req_fire),
    .raddr_i (set_idx),
    .rdata_o (tag_rd)
  );

  tas_ram #(
    .WIDTH (META_W),
    .DEPTH (DEPTH)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (req_fire),
    .raddr_i (set_idx),
    .rdata_o (meta_rd)
  );

  tas_lru #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS),
    .RW       (RW)
  ) u_lru (
    .mode_i   (mode_q),
    .tag_i    (tag_q),
    .tags_i   (tags_rd),
    .valid_i  (valid_rd),
    .rank_i   (rank_rd),
    .tag_we_o (lru_tag_we),
    .tags_o   (tags_new),
    .valid_o  (valid_new),
    .rank_o   (rank_new),
    .res_o    (lru_res)
  );

  always_comb begin
    lookup_cnt_d = lookup_cnt_q;
    hit_cnt_d    = hit_cnt_q;
    if (exec_go && (mode_q == tas_pkg::MODE_LOOKUP)) begin
      lookup_cnt_d = lookup_cnt_q + 1'b1;
      if (lru_res.hit) begin
        hit_cnt_d = hit_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      mode_q       <= tas_pkg::MODE_LOOKUP;
      set_q        <= '0;
      tag_q        <= '0;
      out_valid_q  <= 1'b0;
      res_q        <= '0;
      lookup_cnt_q <= '0;
      hit_cnt_q    <= '0;
    end else begin
      lookup_cnt_q <= lookup_cnt_d;
      hit_cnt_q    <= hit_cnt_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
        res_q       <= lru_res;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == IDX_W'(LAST_SET)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            state_q <= ST_EXEC;
            mode_q  <= tas_pkg::mode_e'(req_i.mode);
            set_q   <= set_idx;
            tag_q   <= tag_ext[TAG_BITS-1:0];
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = res_q.hit;
  assign rsp_o.fill_done     = res_q.fill_done;
  assign rsp_o.erase_done    = res_q.erase_done;
  assign rsp_o.evicted_valid = res_q.evicted_valid;
  assign rsp_o.evicted_tag   = res_q.evicted_tag;
  assign rsp_o.lookup_count  = lookup_cnt_q;
  assign rsp_o.hit_count     = hit_cnt_q;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      mru_mask[w] = (rank_new[w] == RW'(WAYS - 1));
    end
  end

  // A taken request moves the unit into the execute state in the next cycle.
  a_fire_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == ST_EXEC))
    else $error("request transfer not followed by execute state");

  // The hit counter only moves together with the lookup counter.
  a_hit_with_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hit_cnt_q) |-> !$stable(lookup_cnt_q))
    else $error("hit counter changed without a lookup");

  // Written-back ranks keep exactly one most-recent way.
  a_one_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |-> $onehot(mru_mask))
    else $error("rank row written back without a single most-recent way");

  // Tag RAM is written only by a fill in the execute state.
  a_tag_we_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_we |-> ((state_q == ST_EXEC) && (mode_q == tas_pkg::MODE_FILL)))
    else $error("tag RAM written outside a fill");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for set_assoc_tag_store_lru_unit: an in-order tag store
// model predicts each response; the driver and monitor apply random idling.
// Depends on tas_pkg, tas_req_if, tas_rsp_if and the unit under test.
`timescale 1ns / 100ps

module tb_top;
  import tas_pkg::*;

  localparam int N_SETS   = 1 << DEF_SET_BITS;
  localparam int N_WAYS   = DEF_WAYS;
  localparam int RANK_W   = (N_WAYS > 1) ? $clog2(N_WAYS) : 1;
  localparam int MODE_TOP = (1 << MODE_W) - 1;
  localparam int TAG_TOP  = (1 << TAG_IN_W) - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SET_IN_W-1:0] set_index;
    logic [TAG_IN_W-1:0] tag;
  } tag_request_t;

  typedef struct packed {
    logic                hit;
    logic                fill_done;
    logic                erase_done;
    logic                evicted_valid;
    logic [TAG_IN_W-1:0] evicted_tag;
    logic [CNT_W-1:0]    lookup_count;
    logic [CNT_W-1:0]    hit_count;
  } tag_result_t;

  logic clk_i;
  logic rst_ni;

  tas_req_if req_if ();
  tas_rsp_if rsp_if ();

  set_assoc_tag_store_lru_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Model of the tag store
  logic [TAG_IN_W-1:0] way_tag   [N_SETS][N_WAYS];
  logic                way_valid [N_SETS][N_WAYS];
  logic [RANK_W-1:0]   way_rank  [N_SETS][N_WAYS];
  logic [CNT_W-1:0]    lookups_seen;
  logic [CNT_W-1:0]    hits_seen;

  tag_request_t pending_reqs[$];
  tag_result_t  expected_rsps[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int quiet_cycles;

  int                  hot_sets [4];
  logic [TAG_IN_W-1:0] hot_tags [6];

  // Way w becomes most recent; ways ranked above its old rank move down one.
  function automatic void promote(int s, int w);
    logic [RANK_W-1:0] old_rank;
    old_rank = way_rank[s][w];
    way_rank[s][w] = RANK_W'(N_WAYS - 1);
    for (int j = 0; j < N_WAYS; j++) begin
      if (j != w && way_rank[s][j] > old_rank) way_rank[s][j] = way_rank[s][j] - 1'b1;
    end
  endfunction

  function automatic int find_way(int s, logic [TAG_IN_W-1:0] t);
    for (int w = 0; w < N_WAYS; w++) begin
      if (way_valid[s][w] && way_tag[s][w] == t) return w;
    end
    return N_WAYS;
  endfunction

  function automatic tag_result_t apply_request(tag_request_t r);
    tag_result_t res;
    int s;
    int w;
    res = '0;
    s = int'(r.set_index);
    case (r.mode)
      MODE_LOOKUP: begin
        lookups_seen = lookups_seen + 1'b1;
        w = find_way(s, r.tag);
        if (w < N_WAYS) begin
          hits_seen = hits_seen + 1'b1;
          promote(s, w);
          res.hit = 1'b1;
        end
      end
      MODE_FILL: begin
        for (w = 0; w < N_WAYS; w++) begin
          if (!way_valid[s][w]) begin
            way_tag[s][w]   = r.tag;
            way_valid[s][w] = 1'b1;
            promote(s, w);
            res.fill_done = 1'b1;
            break;
          end
        end
      end
      MODE_TOUCH: begin
        w = find_way(s, r.tag);
        if (w < N_WAYS) begin
          promote(s, w);
          res.hit = 1'b1;
        end
      end
      MODE_EVICT: begin
        // ranks untouched; an empty LRU way reports nothing
        for (w = 0; w < N_WAYS; w++) begin
          if (way_rank[s][w] == '0) begin
            if (way_valid[s][w]) begin
              res.evicted_valid = 1'b1;
              res.evicted_tag   = way_tag[s][w];
            end
            way_valid[s][w] = 1'b0;
            break;
          end
        end
      end
      MODE_ERASE: begin
        w = find_way(s, r.tag);
        if (w < N_WAYS) begin
          way_valid[s][w] = 1'b0;
          res.erase_done = 1'b1;
        end
      end
      default: ;
    endcase
    res.lookup_count = lookups_seen;
    res.hit_count    = hits_seen;
    return res;
  endfunction

  function automatic string show_result(tag_result_t r);
    return $sformatf("hit=%0b fill=%0b erase=%0b ev_valid=%0b ev_tag=%05h lookups=%0d hits=%0d",
                     r.hit, r.fill_done, r.erase_done, r.evicted_valid, r.evicted_tag,
                     r.lookup_count, r.hit_count);
  endfunction

  function automatic tag_request_t random_request();
    tag_request_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 35)      r.mode = MODE_LOOKUP;
    else if (roll < 55) r.mode = MODE_FILL;
    else if (roll < 68) r.mode = MODE_TOUCH;
    else if (roll < 82) r.mode = MODE_EVICT;
    else if (roll < 95) r.mode = MODE_ERASE;
    else                r.mode = MODE_W'($urandom_range(MODE_TOP, int'(MODE_ERASE) + 1));
    // a few busy sets and tags so hits, full sets and evictions are frequent
    if ($urandom_range(99) < 80) r.set_index = SET_IN_W'(hot_sets[$urandom_range(3)]);
    else                         r.set_index = SET_IN_W'($urandom_range(N_SETS - 1));
    if ($urandom_range(99) < 75) r.tag = hot_tags[$urandom_range(5)];
    else                         r.tag = TAG_IN_W'($urandom_range(TAG_TOP));
    return r;
  endfunction

  task automatic add_request(logic [MODE_W-1:0] mode, int s, logic [TAG_IN_W-1:0] t);
    tag_request_t r;
    r.mode      = mode;
    r.set_index = SET_IN_W'(s);
    r.tag       = t;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Sender holds off until every response is back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_if.valid);
  endtask

  task automatic run_phase(int n_items, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    foreach (hot_sets[i]) hot_sets[i] = $urandom_range(N_SETS - 1);
    foreach (hot_tags[i]) hot_tags[i] = TAG_IN_W'($urandom_range(TAG_TOP));
    for (int i = 0; i < n_items; i++) pending_reqs.insert(pending_reqs.size(), random_request());
    wait_drained();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: a presented transfer stays put until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.insert(expected_rsps.size(), apply_request(pending_reqs.pop_front()));
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid     <= 1'b1;
          req_if.mode      <= pending_reqs[0].mode;
          req_if.set_index <= pending_reqs[0].set_index;
          req_if.tag       <= pending_reqs[0].tag;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and checker
  always @(posedge clk_i) begin
    tag_result_t got;
    tag_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.hit           = rsp_if.hit;
      got.fill_done     = rsp_if.fill_done;
      got.erase_done    = rsp_if.erase_done;
      got.evicted_valid = rsp_if.evicted_valid;
      got.evicted_tag   = rsp_if.evicted_tag;
      got.lookup_count  = rsp_if.lookup_count;
      got.hit_count     = rsp_if.hit_count;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("%0t: unexpected response: %s", $realtime, show_result(got));
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS) begin
            $display("%0t: response mismatch", $realtime);
            $display("  expected: %s", show_result(want));
            $display("  actual:   %s", show_result(got));
          end
        end
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.mode      = MODE_LOOKUP;
    req_if.set_index = '0;
    req_if.tag       = '0;
    rsp_if.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    lookups_seen     = '0;
    hits_seen        = '0;
    for (int s = 0; s < N_SETS; s++) begin
      for (int w = 0; w < N_WAYS; w++) begin
        way_valid[s][w] = 1'b0;
        way_rank[s][w]  = RANK_W'(w);
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty set: lookup miss, evict of an empty way, touch and erase misses
    add_request(MODE_LOOKUP, 0, '0);
    add_request(MODE_EVICT, 0, '0);
    add_request(MODE_TOUCH, 0, '0);
    add_request(MODE_ERASE, 0, '0);
    // fill every way, then a fill into a full set
    add_request(MODE_FILL, 0, '0);
    add_request(MODE_FILL, 0, TAG_IN_W'(TAG_TOP));
    add_request(MODE_FILL, 0, 20'h12345);
    add_request(MODE_FILL, 0, 20'hABCDE);
    add_request(MODE_FILL, 0, 20'h55555);
    add_request(MODE_LOOKUP, 0, TAG_IN_W'(TAG_TOP));
    add_request(MODE_TOUCH, 0, '0);
    add_request(MODE_LOOKUP, 0, 20'h55555);
    add_request(MODE_EVICT, 0, '0);
    add_request(MODE_ERASE, 0, 20'hABCDE);
    add_request(MODE_ERASE, 0, 20'hABCDE);
    // top set, then unused codes
    add_request(MODE_FILL, N_SETS - 1, TAG_IN_W'(TAG_TOP));
    add_request(MODE_LOOKUP, N_SETS - 1, TAG_IN_W'(TAG_TOP));
    add_request(MODE_EVICT, N_SETS - 1, '0);
    for (int m = int'(MODE_ERASE) + 1; m <= MODE_TOP; m++)
      add_request(MODE_W'(m), N_SETS - 1, TAG_IN_W'(TAG_TOP));
    add_request(MODE_LOOKUP, 0, '0);
    add_request(MODE_FILL, 0, 20'h2AAAA);
    wait_drained();

    run_phase(530, 12, 70);
    run_phase(530, 70, 12);
    run_phase(540, 0, 0);

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tas_pkg.sv
sv/tas_req_if.sv
sv/tas_rsp_if.sv
sv/tas_ram.sv
sv/tas_lru.sv
sv/set_assoc_tag_store_lru_unit.sv
tb/sv/tb_top.sv
